FILE: rtl/dcsr_pkg.sv
`timescale 1ns / 1ps

package dcsr_pkg;

    localparam int COUNT_W = 8;
    localparam int SUM_W   = 20;
    localparam int MEAN_W  = 28;
    localparam int FRAC_W  = 8;

    typedef enum logic [1:0] {
        MUL_PART,
        MUL_SIG,
        MUL_TAU
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     halve;
        logic     clr_ep;
        logic     next_d;
        logic     tail_set;
        logic     div_trial;
        logic     div_take;
        logic     div_mean;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     wr_part;
        logic     wr_sig;
        logic     wr_tau;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic rem_even;
        logic e_nonzero;
        logic sq_gt_rem;
        logic rem_gt_one;
        logic div_busy;
        logic div_rem_zero;
        logic mul_busy;
    } sts_t;

endpackage

FILE: rtl/dcsr_in_if.sv
`timescale 1ns / 1ps

interface dcsr_in_if #(
    parameter int N_WIDTH = 17
);
    logic               valid;
    logic               ready;
    logic [N_WIDTH-1:0] n;

    modport source (output valid, output n, input ready);
    modport sink   (input valid, input n, output ready);
endinterface

FILE: rtl/dcsr_out_if.sv
`timescale 1ns / 1ps

interface dcsr_out_if;
    logic                         valid;
    logic                         ready;
    logic                         bad_input;
    logic [dcsr_pkg::COUNT_W-1:0] divisor_count;
    logic [dcsr_pkg::SUM_W-1:0]   divisor_sum;
    logic [dcsr_pkg::MEAN_W-1:0]  mean_divisor;

    modport source (
        output valid, output bad_input, output divisor_count,
        output divisor_sum, output mean_divisor, input ready
    );
    modport sink (
        input valid, input bad_input, input divisor_count,
        input divisor_sum, input mean_divisor, output ready
    );
endinterface

FILE: rtl/dcsr_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module dcsr_div #(
    parameter int DVD_W  = 28,
    parameter int DVS_W  = 17,
    parameter int STEP_W = $clog2(DVD_W + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              busy,
    output logic [DVD_W-1:0]  quotient,
    output logic              rem_zero
);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  q_reg;
    logic [DVS_W-1:0]  prem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign trial = {prem_reg, q_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= dividend;
            prem_reg <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg    <= {q_reg[DVD_W-2:0], ge};
            prem_reg <= ge ? DVS_W'(diff) : DVS_W'(trial);
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
    assign rem_zero = (prem_reg == '0);

endmodule

FILE: rtl/dcsr_mul.sv
`timescale 1ns / 1ps

// shift-add multiplier, stops when the multiplier runs out of ones
module dcsr_mul #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         busy,
    output logic [W-1:0] product
);

    logic         busy_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (b_reg == '0))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/dcsr_dpath.sv
`timescale 1ns / 1ps

module dcsr_dpath #(
    parameter int N_WIDTH = 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dcsr_pkg::cmd_t               cmd,
    output dcsr_pkg::sts_t               sts,
    input  logic [N_WIDTH-1:0]           n,
    output logic                         bad_input,
    output logic [dcsr_pkg::COUNT_W-1:0] divisor_count,
    output logic [dcsr_pkg::SUM_W-1:0]   divisor_sum,
    output logic [dcsr_pkg::MEAN_W-1:0]  mean_divisor
);

    localparam int COUNT_W = dcsr_pkg::COUNT_W;
    localparam int SUM_W   = dcsr_pkg::SUM_W;
    localparam int MEAN_W  = dcsr_pkg::MEAN_W;
    localparam int FRAC_W  = dcsr_pkg::FRAC_W;
    // sigma(n) < 8n over the whole parameter range, tau(n) <= 2*sqrt(n)
    localparam int SIG_W   = N_WIDTH + 3;
    localparam int TAU_W   = N_WIDTH / 2 + 2;
    localparam int D_W     = N_WIDTH / 2 + 2;
    localparam int SQ_W    = N_WIDTH + 2;
    localparam int E_W     = $clog2(N_WIDTH + 1);
    localparam int DVD_W   = SIG_W + FRAC_W;
    localparam int LIFT    = DVD_W - N_WIDTH;
    localparam int STEP_W  = $clog2(DVD_W + 1);

    logic [N_WIDTH-1:0] rem_reg;
    logic [D_W-1:0]     d_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [E_W-1:0]     e_reg;
    logic [SIG_W-1:0]   part_reg;
    logic [SIG_W-1:0]   sigma_reg;
    logic [TAU_W-1:0]   tau_reg;
    logic               bad_reg;

    logic               bad_out_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic [SUM_W-1:0]   sum_out_reg;
    logic [MEAN_W-1:0]  mean_out_reg;

    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [N_WIDTH-1:0] div_dvs;
    logic [STEP_W-1:0]  div_steps;
    logic               div_busy;
    logic [DVD_W-1:0]   div_q;
    logic               div_rem_zero;

    logic [SIG_W-1:0]   mul_a;
    logic [SIG_W-1:0]   mul_b;
    logic               mul_busy;
    logic [SIG_W-1:0]   mul_p;

    assign div_start = cmd.div_trial | cmd.div_mean;
    assign div_dvd   = cmd.div_mean ? {sigma_reg, {FRAC_W{1'b0}}} : {rem_reg, {LIFT{1'b0}}};
    assign div_dvs   = cmd.div_mean ? N_WIDTH'(tau_reg) : N_WIDTH'(d_reg);
    assign div_steps = cmd.div_mean ? STEP_W'(DVD_W) : STEP_W'(N_WIDTH);

    always_comb
    begin
        case (cmd.mul_sel)
            dcsr_pkg::MUL_PART:
            begin
                mul_a = part_reg;
                mul_b = SIG_W'(d_reg);
            end
            dcsr_pkg::MUL_SIG:
            begin
                mul_a = sigma_reg;
                mul_b = part_reg;
            end
            dcsr_pkg::MUL_TAU:
            begin
                mul_a = SIG_W'(tau_reg);
                mul_b = SIG_W'(e_reg) + SIG_W'(1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dcsr_div #(
        .DVD_W (DVD_W),
        .DVS_W (N_WIDTH),
        .STEP_W(STEP_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .steps   (div_steps),
        .busy    (div_busy),
        .quotient(div_q),
        .rem_zero(div_rem_zero)
    );

    dcsr_mul #(
        .W(SIG_W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .product(mul_p)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= n;
        end
        else if (cmd.halve)
        begin
            rem_reg <= {1'b0, rem_reg[N_WIDTH-1:1]};
        end
        else if (cmd.div_take)
        begin
            rem_reg <= div_q[N_WIDTH-1:0];
        end

        if (cmd.load || cmd.clr_ep)
        begin
            e_reg <= '0;
        end
        else if (cmd.tail_set)
        begin
            e_reg <= E_W'(1);
        end
        else if (cmd.halve || cmd.div_take)
        begin
            e_reg <= e_reg + E_W'(1);
        end

        if (cmd.load || cmd.clr_ep)
        begin
            part_reg <= SIG_W'(1);
        end
        else if (cmd.halve)
        begin
            part_reg <= {part_reg[SIG_W-2:0], 1'b1};
        end
        else if (cmd.tail_set)
        begin
            part_reg <= SIG_W'(rem_reg) + SIG_W'(1);
        end
        else if (cmd.wr_part)
        begin
            part_reg <= mul_p + SIG_W'(1);
        end

        if (cmd.load)
        begin
            sigma_reg <= SIG_W'(1);
            tau_reg   <= TAU_W'(1);
            bad_reg   <= (n == '0);
        end
        else
        begin
            if (cmd.wr_sig)
            begin
                sigma_reg <= mul_p;
            end
            if (cmd.wr_tau)
            begin
                tau_reg <= TAU_W'(mul_p);
            end
        end

        // (d+2)^2 = d^2 + 4d + 4
        if (cmd.load)
        begin
            d_reg  <= D_W'(3);
            sq_reg <= SQ_W'(9);
        end
        else if (cmd.next_d)
        begin
            d_reg  <= d_reg + D_W'(2);
            sq_reg <= sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);
        end

        if (cmd.out_load)
        begin
            bad_out_reg <= bad_reg;
            if (bad_reg)
            begin
                count_out_reg <= '0;
                sum_out_reg   <= '0;
                mean_out_reg  <= '0;
            end
            else
            begin
                count_out_reg <= ((tau_reg >> COUNT_W) != '0) ? '1 : COUNT_W'(tau_reg);
                sum_out_reg   <= ((sigma_reg >> SUM_W) != '0) ? '1 : SUM_W'(sigma_reg);
                mean_out_reg  <= ((div_q >> MEAN_W) != '0) ? '1 : MEAN_W'(div_q);
            end
        end
    end

    assign sts.bad          = bad_reg;
    assign sts.rem_even     = ~rem_reg[0];
    assign sts.e_nonzero    = (e_reg != '0);
    assign sts.sq_gt_rem    = (sq_reg > SQ_W'(rem_reg));
    assign sts.rem_gt_one   = (rem_reg > N_WIDTH'(1));
    assign sts.div_busy     = div_busy;
    assign sts.div_rem_zero = div_rem_zero;
    assign sts.mul_busy     = mul_busy;

    assign bad_input     = bad_out_reg;
    assign divisor_count = count_out_reg;
    assign divisor_sum   = sum_out_reg;
    assign mean_divisor  = mean_out_reg;

endmodule

FILE: rtl/dcsr_ctrl.sv
`timescale 1ns / 1ps

module dcsr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           query_valid,
    output logic           query_ready,
    output logic           result_valid,
    input  logic           result_ready,
    input  dcsr_pkg::sts_t sts,
    output dcsr_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TWO,
        S_CHECK,
        S_DIV,
        S_PMUL,
        S_TAIL,
        S_WSIG,
        S_WTAU,
        S_MEAN_GO,
        S_MEAN,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_TWO,
        PH_ODD,
        PH_TAIL
    } phase_t;

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;
    logic   valid_reg;
    logic   valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_sel = dcsr_pkg::MUL_PART;
        state_next = state_reg;
        phase_next = phase_reg;
        valid_next = valid_reg & ~result_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (query_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = PH_TWO;
                    state_next = S_TWO;
                end
            end
            S_TWO:
            begin
                if (sts.bad)
                begin
                    state_next = S_OUT;
                end
                else if (sts.rem_even)
                begin
                    cmd.halve = 1'b1;
                end
                else if (sts.e_nonzero)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = dcsr_pkg::MUL_SIG;
                    phase_next    = PH_TWO;
                    state_next    = S_WSIG;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.sq_gt_rem)
                begin
                    cmd.div_trial = 1'b1;
                    state_next    = S_DIV;
                end
                else if (sts.rem_gt_one)
                begin
                    cmd.tail_set = 1'b1;
                    state_next   = S_TAIL;
                end
                else
                begin
                    state_next = S_MEAN_GO;
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.div_rem_zero)
                    begin
                        cmd.div_take  = 1'b1;
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = dcsr_pkg::MUL_PART;
                        state_next    = S_PMUL;
                    end
                    else if (sts.e_nonzero)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = dcsr_pkg::MUL_SIG;
                        phase_next    = PH_ODD;
                        state_next    = S_WSIG;
                    end
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_PMUL:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.wr_part   = 1'b1;
                    cmd.div_trial = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_TAIL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = dcsr_pkg::MUL_SIG;
                phase_next    = PH_TAIL;
                state_next    = S_WSIG;
            end
            S_WSIG:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.wr_sig    = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = dcsr_pkg::MUL_TAU;
                    state_next    = S_WTAU;
                end
            end
            S_WTAU:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.wr_tau = 1'b1;
                    case (phase_reg)
                        PH_TWO:
                        begin
                            cmd.clr_ep = 1'b1;
                            state_next = S_CHECK;
                        end
                        PH_ODD:
                        begin
                            cmd.clr_ep = 1'b1;
                            cmd.next_d = 1'b1;
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_MEAN_GO;
                        end
                    endcase
                end
            end
            S_MEAN_GO:
            begin
                cmd.div_mean = 1'b1;
                state_next   = S_MEAN;
            end
            S_MEAN:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_TWO;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign query_ready  = (state_reg == S_IDLE);
    assign result_valid = valid_reg;

endmodule

FILE: rtl/divisor_count_sum_ratio.sv
// Work per item: trial divides by each odd divisor up to the square root of the cofactor,
//   shift-add multiplies for the divisor sum and count, and a final divide for the mean;
//   numbers with small factors finish sooner.
// Throughput: one item at a time; set by the bit-serial trial divider loop.
// The next item is taken while a finished result waits in the output register.
// Reset: asynchronous active-low, clears the controller and output valid.
`timescale 1ns / 1ps

module divisor_count_sum_ratio #(
    parameter int N_WIDTH = 17
) (
    input logic        clk,
    input logic        rst_n,
    dcsr_in_if.sink    query,
    dcsr_out_if.source result
);

    dcsr_pkg::cmd_t cmd;
    dcsr_pkg::sts_t sts;

    dcsr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query.valid),
        .query_ready (query.ready),
        .result_valid(result.valid),
        .result_ready(result.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    dcsr_dpath #(
        .N_WIDTH(N_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .n            (query.n),
        .bad_input    (result.bad_input),
        .divisor_count(result.divisor_count),
        .divisor_sum  (result.divisor_sum),
        .mean_divisor (result.mean_divisor)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready) |=> !query.ready)
        else $error("input taken while an item is in progress");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.bad_input) |->
        (result.divisor_count == '0 && result.divisor_sum == '0 &&
         result.mean_divisor == '0))
        else $error("nonzero result on bad input");

    a_sum_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.bad_input) |->
        (result.divisor_count != '0 &&
         {12'd0, result.divisor_count} <= result.divisor_sum))
        else $error("divisor sum below divisor count");

    a_mean_ge_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.bad_input) |-> (result.mean_divisor >= 28'd256))
        else $error("mean divisor below one");

endmodule
